// ===== sv/nfcrfc_pkg.sv =====
package nfcrfc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 4;

    localparam logic [BYTE_W-1:0] PREAMBLE_BYTE   = 8'h00;
    localparam logic [BYTE_W-1:0] START_CODE_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] POSTAMBLE_BYTE  = 8'h00;
    localparam logic [BYTE_W-1:0] FRAME_TFI       = 8'hD5;
    localparam logic [BYTE_W-1:0] ERR_LEN         = 8'h01;
    localparam logic [BYTE_W-1:0] ERR_LCS         = 8'hFF;
    localparam logic [BYTE_W-1:0] EXT_LEN         = 8'hFF;
    localparam logic [BYTE_W-1:0] EXT_LCS         = 8'hFF;
    localparam logic [BYTE_W:0]   LEN_SUM_TARGET  = 9'h100;
    localparam logic [BYTE_W-1:0] LEN_OVERHEAD    = 8'd2;

    localparam logic [BYTE_W-1:0] EXPECTED_COMMAND_RESET = 8'd0;
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RESET      = 8'd253;

    // configuration register indexes
    localparam logic CFG_EXPECTED_COMMAND = 1'b0;
    localparam logic CFG_MAX_PAYLOAD      = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 4'd0,
        ST_PREAMBLE    = 4'd1,
        ST_ERROR_FRAME = 4'd2,
        ST_LENGTH_SUM  = 4'd3,
        ST_TOO_LONG    = 4'd4,
        ST_TFI         = 4'd5,
        ST_CODE        = 4'd6,
        ST_DATA_SUM    = 4'd7,
        ST_POSTAMBLE   = 4'd8
    } t_status;

    // each state names the byte expected next
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_PRE1,
        PH_PRE2,
        PH_START,
        PH_LEN,
        PH_LCS,
        PH_TFI,
        PH_CODE,
        PH_DATA,
        PH_DCS,
        PH_POST
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              is_data;
        logic              is_end;
        t_status           status;
        logic [BYTE_W-1:0] payload_length;
    } t_result;

endpackage

// ===== sv/nfc_response_frame_checker_core.sv =====
// channel | valid      | stall       | beat fields
// in      | i_in_valid | o_in_stall  | i_rx_byte, i_first_byte
// out     | o_out_valid| i_out_stall | o_data_byte, o_is_data, o_is_end, o_status,
//         |            |             | o_payload_length
// cfg     | i_cfg_we   | -           | i_cfg_idx, i_cfg_data
//
// one byte a cycle while o_in_stall is low: the parse state machine is updated in the cycle a beat is accepted
// and its result is registered into the output register, or into the skid register if the output is stalled
// a skid register behind the output register lets input acceptance go on past a stalled
// output until it fills; o_in_stall rises only while the skid register is full
// synchronous active-low reset returns to waiting for a first byte, empty output side
module nfc_response_frame_checker_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [nfcrfc_pkg::BYTE_W-1:0]   i_rx_byte,
    input  logic                            i_first_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [nfcrfc_pkg::BYTE_W-1:0]   o_data_byte,
    output logic                            o_is_data,
    output logic                            o_is_end,
    output logic [nfcrfc_pkg::STATUS_W-1:0] o_status,
    output logic [nfcrfc_pkg::BYTE_W-1:0]   o_payload_length,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [nfcrfc_pkg::BYTE_W-1:0]   i_cfg_data
);
    import nfcrfc_pkg::*;

    logic [BYTE_W-1:0] r_expected_command;
    logic [BYTE_W-1:0] r_max_payload;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_len, n_len;
    logic [BYTE_W-1:0] r_left, n_left;
    logic [BYTE_W-1:0] r_sum, n_sum;

    t_result           r_out, r_skd;
    logic              r_out_valid, r_skd_valid;

    t_phase            cur_phase;
    logic              in_fire, out_fire;
    logic              res_valid;
    t_result           res;
    logic [BYTE_W:0]   len_sum;
    logic [BYTE_W-1:0] len_net;
    logic [BYTE_W-1:0] sum_plus;
    logic [BYTE_W-1:0] left_dec;
    logic [BYTE_W:0]   code_want;

    assign in_fire   = i_in_valid && !r_skd_valid;
    assign out_fire  = r_out_valid && !i_out_stall;
    assign cur_phase = i_first_byte ? PH_PRE1 : r_phase;
    assign len_sum   = {1'b0, r_len} + {1'b0, i_rx_byte};
    assign len_net   = r_len - LEN_OVERHEAD;
    assign sum_plus  = r_sum + i_rx_byte;
    assign left_dec  = r_left - 8'd1;
    assign code_want = {1'b0, r_expected_command} + 9'd1;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_command <= EXPECTED_COMMAND_RESET;
            r_max_payload      <= MAX_PAYLOAD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EXPECTED_COMMAND: r_expected_command <= i_cfg_data;
                CFG_MAX_PAYLOAD:      r_max_payload      <= i_cfg_data;
                default:              r_max_payload      <= r_max_payload;
            endcase
        end
    end

    // next state
    always_comb begin
        n_phase = cur_phase;
        n_len   = r_len;
        n_left  = r_left;
        n_sum   = r_sum;
        case (cur_phase)
            PH_IDLE: n_phase = PH_IDLE;
            PH_PRE1: n_phase = (i_rx_byte == PREAMBLE_BYTE) ? PH_PRE2 : PH_IDLE;
            PH_PRE2: n_phase = (i_rx_byte == PREAMBLE_BYTE) ? PH_START : PH_IDLE;
            PH_START: n_phase = (i_rx_byte == START_CODE_BYTE) ? PH_LEN : PH_IDLE;
            PH_LEN: begin
                n_len   = i_rx_byte;
                n_phase = PH_LCS;
            end
            PH_LCS: begin
                n_left = len_net;
                if ((r_len == ERR_LEN && i_rx_byte == ERR_LCS) ||
                    (r_len == EXT_LEN && i_rx_byte == EXT_LCS) ||
                    len_sum != LEN_SUM_TARGET ||
                    r_len < LEN_OVERHEAD || len_net > r_max_payload) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = PH_TFI;
                end
            end
            PH_TFI: begin
                n_sum   = FRAME_TFI;
                n_phase = (i_rx_byte == FRAME_TFI) ? PH_CODE : PH_IDLE;
            end
            PH_CODE: begin
                n_sum = sum_plus;
                if ({1'b0, i_rx_byte} != code_want) begin
                    n_phase = PH_IDLE;
                end else if (r_left == '0) begin
                    n_phase = PH_DCS;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                n_sum   = sum_plus;
                n_left  = left_dec;
                n_phase = (left_dec == '0) ? PH_DCS : PH_DATA;
            end
            PH_DCS: n_phase = (sum_plus == '0) ? PH_POST : PH_IDLE;
            PH_POST: n_phase = PH_IDLE;
            default: n_phase = PH_IDLE;
        endcase
    end

    // result for the beat
    always_comb begin
        res_valid          = 1'b0;
        res.data_byte      = '0;
        res.is_data        = 1'b0;
        res.is_end         = 1'b1;
        res.status         = ST_OK;
        res.payload_length = '0;
        case (cur_phase)
            PH_PRE1, PH_PRE2: begin
                res_valid  = (i_rx_byte != PREAMBLE_BYTE);
                res.status = ST_PREAMBLE;
            end
            PH_START: begin
                res_valid  = (i_rx_byte != START_CODE_BYTE);
                res.status = ST_PREAMBLE;
            end
            PH_LCS: begin
                res_valid = 1'b1;
                if (r_len == ERR_LEN && i_rx_byte == ERR_LCS) begin
                    res.status = ST_ERROR_FRAME;
                end else if (r_len == EXT_LEN && i_rx_byte == EXT_LCS) begin
                    res.status = ST_POSTAMBLE;
                end else if (len_sum != LEN_SUM_TARGET) begin
                    res.status = ST_LENGTH_SUM;
                end else if (r_len < LEN_OVERHEAD || len_net > r_max_payload) begin
                    res.status = ST_TOO_LONG;
                end else begin
                    res_valid = 1'b0;
                end
            end
            PH_TFI: begin
                res_valid  = (i_rx_byte != FRAME_TFI);
                res.status = ST_TFI;
            end
            PH_CODE: begin
                res_valid  = ({1'b0, i_rx_byte} != code_want);
                res.status = ST_CODE;
            end
            PH_DATA: begin
                res_valid     = 1'b1;
                res.data_byte = i_rx_byte;
                res.is_data   = 1'b1;
                res.is_end    = 1'b0;
            end
            PH_DCS: begin
                res_valid  = (sum_plus != '0);
                res.status = ST_DATA_SUM;
            end
            PH_POST: begin
                res_valid = 1'b1;
                if (i_rx_byte != POSTAMBLE_BYTE) begin
                    res.status = ST_POSTAMBLE;
                end else begin
                    res.payload_length = len_net;
                end
            end
            default: res_valid = 1'b0;
        endcase
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_len   <= '0;
            r_left  <= '0;
            r_sum   <= '0;
        end else if (in_fire) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_left  <= n_left;
            r_sum   <= n_sum;
        end
    end

    // output register and skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (r_skd_valid) begin
            if (out_fire) begin
                r_out_valid <= 1'b1;
                r_skd_valid <= 1'b0;
            end
        end else if (in_fire && res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skd_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_valid) begin
            if (out_fire) begin
                r_out <= r_skd;
            end
        end else if (in_fire && res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out <= res;
            end else begin
                r_skd <= res;
            end
        end
    end

    assign o_in_stall       = r_skd_valid;
    assign o_out_valid      = r_out_valid;
    assign o_data_byte      = r_out.data_byte;
    assign o_is_data        = r_out.is_data;
    assign o_is_end         = r_out.is_end;
    assign o_status         = r_out.status;
    assign o_payload_length = r_out.payload_length;

endmodule

// ===== sv/nfcrfc_checker.sv =====
module nfcrfc_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_in_stall,
    input  logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  logic [nfcrfc_pkg::BYTE_W-1:0]   o_data_byte,
    input  logic                            o_is_data,
    input  logic                            o_is_end,
    input  logic [nfcrfc_pkg::STATUS_W-1:0] o_status,
    input  logic [nfcrfc_pkg::BYTE_W-1:0]   o_payload_length
);
    import nfcrfc_pkg::*;

    // a stalled result beat stays, unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_data_byte) &&
            $stable(o_is_data) && $stable(o_is_end) && $stable(o_status) &&
            $stable(o_payload_length))
        else $error("result beat dropped or changed while stalled");

    // every result is exactly one of data or end
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_data != o_is_end))
        else $error("result is neither or both of data and end");

    // data beats carry no status and no length
    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_data |-> (o_status == ST_OK && o_payload_length == '0))
        else $error("data beat carries status or length");

    // failed frames report no length
    a_err_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_end && o_status != ST_OK |-> o_payload_length == '0)
        else $error("error status with non-zero length");

    // reset empties the output side
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("output side not empty after reset");

endmodule

bind nfc_response_frame_checker_core nfcrfc_checker u_nfcrfc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_data_byte      (o_data_byte),
    .o_is_data        (o_is_data),
    .o_is_end         (o_is_end),
    .o_status         (o_status),
    .o_payload_length (o_payload_length)
);

// ===== tb/sv/nfc_response_frame_checker_core_tb.sv =====
module nfc_response_frame_checker_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import nfcrfc_pkg::*;

    localparam int unsigned WATCHDOG_CYCLES = 2000;
    localparam int unsigned LONG_HOLD       = 100;
    localparam int unsigned SETTLE_CYCLES   = 8;

    typedef enum int unsigned {
        FLT_NONE,
        FLT_PREAMBLE,
        FLT_ERROR_FRAME,
        FLT_EXTENDED,
        FLT_LENGTH_SUM,
        FLT_TOO_LONG,
        FLT_TFI,
        FLT_CODE,
        FLT_DATA_SUM,
        FLT_POSTAMBLE,
        FLT_TRUNCATE
    } t_frame_fault;

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_in_valid       = 1'b0;
    logic                o_in_stall;
    logic [BYTE_W-1:0]   i_rx_byte        = '0;
    logic                i_first_byte     = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall      = 1'b0;
    logic [BYTE_W-1:0]   o_data_byte;
    logic                o_is_data;
    logic                o_is_end;
    logic [STATUS_W-1:0] o_status;
    logic [BYTE_W-1:0]   o_payload_length;
    logic                i_cfg_we         = 1'b0;
    logic                i_cfg_idx        = CFG_EXPECTED_COMMAND;
    logic [BYTE_W-1:0]   i_cfg_data       = '0;

    nfc_response_frame_checker_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .i_first_byte     (i_first_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_data_byte      (o_data_byte),
        .o_is_data        (o_is_data),
        .o_is_end         (o_is_end),
        .o_status         (o_status),
        .o_payload_length (o_payload_length),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // frame parser mirror
    t_phase            rx_phase        = PH_IDLE;
    logic [BYTE_W-1:0] rx_len          = '0;
    logic [BYTE_W-1:0] rx_left         = '0;
    logic [BYTE_W-1:0] rx_sum          = '0;
    logic [BYTE_W-1:0] cfg_command     = EXPECTED_COMMAND_RESET;
    logic [BYTE_W-1:0] cfg_max_payload = MAX_PAYLOAD_RESET;

    t_result           frame_results_q[$];
    logic [BYTE_W-1:0] frame_bytes[$];

    int unsigned items_sent  = 0;
    int unsigned mismatches  = 0;
    int unsigned burst_left  = 0;
    int unsigned gap_max     = 0;
    int unsigned stall_pct   = 0;
    int unsigned stall_run   = 0;
    int unsigned hold_left   = 0;
    int unsigned hold_seq    = 0;
    int unsigned hold_seen   = 0;
    int unsigned quiet_cycles = 0;

    function automatic void close_frame(output t_result res, output logic produced,
                                        input t_status code, input logic [BYTE_W-1:0] plen);
        res                = '0;
        res.is_end         = 1'b1;
        res.status         = code;
        res.payload_length = plen;
        produced           = 1'b1;
        rx_phase           = PH_IDLE;
    endfunction

    function automatic void predict_frame_byte(input logic [BYTE_W-1:0] b, input logic first,
                                               output logic produced, output t_result res);
        res      = '0;
        produced = 1'b0;
        if (first)
            rx_phase = PH_PRE1;
        case (rx_phase)
            PH_PRE1: begin
                if (b != PREAMBLE_BYTE) close_frame(res, produced, ST_PREAMBLE, '0);
                else rx_phase = PH_PRE2;
            end
            PH_PRE2: begin
                if (b != PREAMBLE_BYTE) close_frame(res, produced, ST_PREAMBLE, '0);
                else rx_phase = PH_START;
            end
            PH_START: begin
                if (b != START_CODE_BYTE) close_frame(res, produced, ST_PREAMBLE, '0);
                else rx_phase = PH_LEN;
            end
            PH_LEN: begin
                rx_len   = b;
                rx_phase = PH_LCS;
            end
            PH_LCS: begin
                if (rx_len == ERR_LEN && b == ERR_LCS)
                    close_frame(res, produced, ST_ERROR_FRAME, '0);
                else if (rx_len == EXT_LEN && b == EXT_LCS)
                    close_frame(res, produced, ST_POSTAMBLE, '0);
                else if (({1'b0, rx_len} + {1'b0, b}) != LEN_SUM_TARGET)
                    close_frame(res, produced, ST_LENGTH_SUM, '0);
                else if (rx_len < LEN_OVERHEAD || (rx_len - LEN_OVERHEAD) > cfg_max_payload)
                    close_frame(res, produced, ST_TOO_LONG, '0);
                else begin
                    rx_left  = rx_len - LEN_OVERHEAD;
                    rx_phase = PH_TFI;
                end
            end
            PH_TFI: begin
                if (b != FRAME_TFI) close_frame(res, produced, ST_TFI, '0);
                else begin
                    rx_sum   = FRAME_TFI;
                    rx_phase = PH_CODE;
                end
            end
            PH_CODE: begin
                if ({1'b0, b} != ({1'b0, cfg_command} + 9'd1))
                    close_frame(res, produced, ST_CODE, '0);
                else begin
                    rx_sum   = rx_sum + b;
                    rx_phase = (rx_left == '0) ? PH_DCS : PH_DATA;
                end
            end
            PH_DATA: begin
                rx_sum        = rx_sum + b;
                rx_left       = rx_left - 8'd1;
                if (rx_left == '0)
                    rx_phase = PH_DCS;
                res.data_byte = b;
                res.is_data   = 1'b1;
                produced      = 1'b1;
            end
            PH_DCS: begin
                if (8'(rx_sum + b) != 8'd0) close_frame(res, produced, ST_DATA_SUM, '0);
                else rx_phase = PH_POST;
            end
            PH_POST: begin
                if (b != POSTAMBLE_BYTE) close_frame(res, produced, ST_POSTAMBLE, '0);
                else close_frame(res, produced, ST_OK, rx_len - LEN_OVERHEAD);
            end
            default: rx_phase = PH_IDLE;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (frame_results_q.size() == 0) begin
                $error("result beat with nothing expected: data_byte %0d status %0d",
                       o_data_byte, o_status);
                mismatches++;
            end else begin
                want = frame_results_q.pop_front();
                check_field("data_byte", want.data_byte, o_data_byte);
                check_field("is_data", 8'(want.is_data), 8'(o_is_data));
                check_field("is_end", 8'(want.is_end), 8'(o_is_end));
                check_field("status", 8'(want.status), 8'(o_status));
                check_field("payload_length", want.payload_length, o_payload_length);
            end
        end
    end

    // receiver: random stall runs, plus a long hold on request
    always @(posedge i_clk) begin
        if (hold_seen != hold_seq) begin
            hold_seen   <= hold_seq;
            hold_left   <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_run != 0) begin
            stall_run <= stall_run - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
            stall_run   <= $urandom_range(3);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("FAIL nfc_response_frame_checker_core");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic first);
        logic    produced;
        t_result res;
        i_in_valid   <= 1'b1;
        i_rx_byte    <= b;
        i_first_byte <= first;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        predict_frame_byte(b, first, produced, res);
        if (produced)
            frame_results_q.push_back(res);
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(12, 1);
            if (gap_max != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(gap_max, 1)) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_frame();
        foreach (frame_bytes[k])
            send_beat(frame_bytes[k], k == 0);
    endtask

    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (frame_results_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [BYTE_W-1:0] command,
                             input logic [BYTE_W-1:0] payload_limit);
        settle_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_EXPECTED_COMMAND;
        i_cfg_data <= command;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MAX_PAYLOAD;
        i_cfg_data <= payload_limit;
        @(posedge i_clk);
        i_cfg_we        <= 1'b0;
        cfg_command     = command;
        cfg_max_payload = payload_limit;
    endtask

    // plen < 0 picks a random size and, half the time, a random fault
    task automatic build_frame(input int plen);
        int unsigned  limit;
        int unsigned  pick;
        int unsigned  size;
        logic [7:0]   lenb;
        logic [7:0]   code;
        logic [7:0]   sum;
        logic [7:0]   d;
        t_frame_fault fault;
        limit = (cfg_max_payload > 253) ? 253 : cfg_max_payload;
        fault = FLT_NONE;
        if (plen < 0) begin
            pick = $urandom_range(99);
            if (pick < 85) plen = $urandom_range((limit < 8) ? limit : 8);
            else if (pick < 99) plen = $urandom_range((limit < 40) ? limit : 40);
            else plen = limit;
            if ($urandom_range(1) == 1)
                fault = t_frame_fault'($urandom_range(int'(FLT_TRUNCATE), int'(FLT_PREAMBLE)));
        end
        lenb = 8'(plen) + LEN_OVERHEAD;
        code = cfg_command + 8'd1;
        frame_bytes = {PREAMBLE_BYTE, PREAMBLE_BYTE, START_CODE_BYTE, lenb, 8'(0 - lenb),
                       FRAME_TFI, code};
        sum = FRAME_TFI + code;
        repeat (plen) begin
            d = 8'($urandom);
            frame_bytes.push_back(d);
            sum += d;
        end
        frame_bytes.push_back(8'(0 - sum));
        frame_bytes.push_back(POSTAMBLE_BYTE);
        size = frame_bytes.size();
        case (fault)
            FLT_PREAMBLE: frame_bytes[$urandom_range(2)] ^= 8'($urandom_range(255, 1));
            FLT_ERROR_FRAME: begin
                frame_bytes[3] = ERR_LEN;
                frame_bytes[4] = ERR_LCS;
            end
            FLT_EXTENDED: begin
                frame_bytes[3] = EXT_LEN;
                frame_bytes[4] = EXT_LCS;
            end
            FLT_LENGTH_SUM: frame_bytes[4] ^= 8'($urandom_range(255, 1));
            FLT_TOO_LONG: begin
                if (cfg_max_payload < 253) begin
                    lenb           = 8'($urandom_range(255, cfg_max_payload + 3));
                    frame_bytes[3] = lenb;
                    frame_bytes[4] = 8'(0 - lenb);
                end
            end
            FLT_TFI:       frame_bytes[5] ^= 8'($urandom_range(255, 1));
            FLT_CODE:      frame_bytes[6] ^= 8'($urandom_range(255, 1));
            FLT_DATA_SUM:  frame_bytes[size-2] ^= 8'($urandom_range(255, 1));
            FLT_POSTAMBLE: frame_bytes[size-1] ^= 8'($urandom_range(255, 1));
            FLT_TRUNCATE:  frame_bytes = frame_bytes[0:$urandom_range(size - 2)];
            default: ;
        endcase
    endtask

    task automatic test_directed_frames();
        logic [7:0] code;
        gap_max   = 3;
        stall_pct = 20;
        code      = EXPECTED_COMMAND_RESET + 8'd1;
        send_beat(8'hFF, 1'b1);
        send_beat(8'h00, 1'b0);
        send_beat(PREAMBLE_BYTE, 1'b1);
        send_beat(PREAMBLE_BYTE, 1'b0);
        send_beat(START_CODE_BYTE, 1'b0);
        send_beat(ERR_LEN, 1'b0);
        send_beat(ERR_LCS, 1'b0);
        frame_bytes = {PREAMBLE_BYTE, PREAMBLE_BYTE, START_CODE_BYTE, LEN_OVERHEAD,
                       8'(0 - LEN_OVERHEAD), FRAME_TFI, code, 8'(0 - (FRAME_TFI + code)),
                       POSTAMBLE_BYTE};
        send_frame();
        // restart mid-frame into an extended frame
        send_beat(PREAMBLE_BYTE, 1'b1);
        send_beat(PREAMBLE_BYTE, 1'b0);
        frame_bytes = {PREAMBLE_BYTE, PREAMBLE_BYTE, START_CODE_BYTE, EXT_LEN, EXT_LCS};
        send_frame();
    endtask

    task automatic test_random_frames(input logic [7:0] command, input logic [7:0] payload_limit,
                                      input int unsigned item_goal, input int unsigned gap,
                                      input int unsigned stall);
        int unsigned start_items;
        configure(command, payload_limit);
        gap_max     = gap;
        stall_pct   = stall;
        start_items = items_sent;
        while (items_sent - start_items < item_goal) begin
            build_frame(-1);
            send_frame();
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(4, 1))
                    send_beat(8'($urandom), $urandom_range(9) == 0);
        end
    endtask

    task automatic test_longest_frame();
        configure(8'($urandom), 8'd253);
        gap_max   = 2;
        stall_pct = 30;
        build_frame(253);
        send_frame();
    endtask

    // long receiver hold while the sender keeps offering
    task automatic test_output_hold();
        configure(8'($urandom), MAX_PAYLOAD_RESET);
        gap_max   = 0;
        stall_pct = 0;
        hold_seq <= hold_seq + 1;
        build_frame(40);
        send_frame();
        build_frame(3);
        send_frame();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_frames();
        test_random_frames(8'd0, 8'd253, 200, 0, 0);
        test_random_frames(8'd255, 8'd0, 100, 4, 30);
        test_random_frames(8'($urandom), 8'd255, 200, 6, 50);
        test_random_frames(8'd254, 8'($urandom_range(12, 1)), 180, 2, 70);
        test_random_frames(8'($urandom), 8'($urandom_range(20)), 180, 8, 40);
        test_longest_frame();
        test_output_hold();
        settle_idle();
        if (mismatches == 0 && frame_results_q.size() == 0)
            $display("PASS nfc_response_frame_checker_core");
        else
            $display("FAIL nfc_response_frame_checker_core");
        $finish;
    end

endmodule
